### rtl/float_to_pcm_sample_converter_top_macros.svh
// assertion macros used by the float to pcm converter queue
`ifndef FLOAT_TO_PCM_SAMPLE_CONVERTER_TOP_MACROS_SVH
`define FLOAT_TO_PCM_SAMPLE_CONVERTER_TOP_MACROS_SVH

// same-cycle implication, checked on the rising edge outside reset
`define FPCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpcm assertion failed");

// next-cycle implication
`define FPCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpcm assertion failed");

`endif

### rtl/fpcm_pkg.sv
// types, codes and rounding helper for the float to pcm converter
package fpcm_pkg;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S32 = 2'd2,
        FMT_F32 = 2'd3
    } t_fmt;

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  last_idx;
    } t_queue_item;

    localparam int unsigned ITEM_W = $bits(t_queue_item);

    // round to 24 significant bits, nearest even
    function automatic logic [40:0] rne24(input logic [39:0] q);
        logic [5:0]  pos;
        logic        found;
        logic [5:0]  drop;
        logic [40:0] ulp;
        logic [40:0] mask;
        logic [40:0] base;
        logic        guard;
        logic        rest;
        logic        lsb;
        pos   = 6'd0;
        found = 1'b0;
        for (int j = 24; j < 40; j++) begin
            if (q[j]) begin
                pos   = 6'(j);
                found = 1'b1;
            end
        end
        if (!found) begin
            return {1'b0, q};
        end
        drop  = pos - 6'd23;
        ulp   = 41'd1 << drop;
        mask  = ulp - 41'd1;
        base  = {1'b0, q} & ~mask;
        guard = q[drop - 6'd1];
        rest  = |({1'b0, q} & (mask >> 1));
        lsb   = q[drop];
        return base + ((guard && (rest || lsb)) ? ulp : 41'd0);
    endfunction

endpackage

### rtl/fpcm_front.sv
// front pipeline: clamps the sample and computes the packed output word
module fpcm_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpcm_pkg::t_fmt       i_fmt,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [31:0]          i_in_data,
    output logic                 o_push,
    output fpcm_pkg::t_queue_item o_push_item,
    input  logic                 i_queue_full
);
    import fpcm_pkg::*;

    logic        en;
    // stage 1
    logic        r_v1;
    logic [31:0] r_bits1;
    t_fmt        r_fmt1;
    logic [31:0] n_bits1;
    // stage 2
    logic        r_v2;
    logic [31:0] r_bits2;
    t_fmt        r_fmt2;
    logic [27:0] r_t2;
    logic [27:0] n_t2;
    // stage 3
    logic        r_v3;
    logic [31:0] r_bits3;
    t_fmt        r_fmt3;
    logic [39:0] r_prod3;
    logic [42:0] n_prod3;
    // stage 4
    logic        r_v4;
    logic [31:0] r_bits4;
    t_fmt        r_fmt4;
    logic [40:0] r_prnd4;

    assign en         = !(r_v4 && i_queue_full);
    assign o_in_ready = en;

    // nan to zero, clamp to +-1
    always_comb begin
        logic [7:0]  e;
        logic [22:0] f;
        e = i_in_data[30:23];
        f = i_in_data[22:0];
        if (e == 8'hFF && f != 23'd0) begin
            n_bits1 = 32'd0;
        end else if (e > 8'd127 || (e == 8'd127 && f != 23'd0)) begin
            n_bits1 = {i_in_data[31], 8'd127, 23'd0};
        end else begin
            n_bits1 = i_in_data;
        end
    end

    // 1 + s rounded to single precision, fixed point with 26 fraction bits
    always_comb begin
        logic [7:0]  ce;
        logic [23:0] m;
        logic [27:0] a;
        logic        st;
        logic [7:0]  sh;
        logic [27:0] t;
        logic        guard;
        logic        rest;
        logic        lsb;
        ce = r_bits1[30:23];
        m  = (ce != 8'd0) ? {1'b1, r_bits1[22:0]} : 24'd0;
        sh = 8'd124 - ce;
        if (ce >= 8'd124) begin
            a  = {4'd0, m} << (ce - 8'd124);
            st = 1'b0;
        end else if (sh >= 8'd24) begin
            a  = 28'd0;
            st = |m;
        end else begin
            a  = {4'd0, m >> sh};
            st = |(m & ((24'd1 << sh) - 24'd1));
        end
        if (r_bits1[31]) begin
            t = 28'h400_0000 - a - {27'd0, st};
        end else begin
            t = 28'h400_0000 + a;
        end
        if (t[27] || t[26]) begin
            guard = t[2];
            rest  = t[1] | t[0] | st;
            lsb   = t[3];
            n_t2  = {t[27:3], 3'b000} + ((guard && (rest || lsb)) ? 28'd8 : 28'd0);
        end else begin
            guard = t[1];
            rest  = t[0] | st;
            lsb   = t[2];
            n_t2  = {t[27:2], 2'b00} + ((guard && (rest || lsb)) ? 28'd4 : 28'd0);
        end
    end

    // one shared multiplier: (1+s)*255 or mantissa*32767
    always_comb begin
        logic [27:0] ma;
        logic [14:0] mb;
        if (r_fmt2 == FMT_U8) begin
            ma = r_t2;
            mb = 15'd255;
        end else begin
            ma = {4'd0, (r_bits2[30:23] != 8'd0), r_bits2[22:0]};
            mb = 15'd32767;
        end
        n_prod3 = {15'd0, ma} * {28'd0, mb};
    end

    // final integer rounding, saturation and packing
    always_comb begin
        logic [7:0]  ce;
        logic [23:0] m;
        logic [40:0] sum8;
        logic [8:0]  k;
        logic [41:0] mag16;
        logic [15:0] w16;
        logic [7:0]  kk;
        logic [32:0] mag32;
        ce    = r_bits4[30:23];
        m     = (ce != 8'd0) ? {1'b1, r_bits4[22:0]} : 24'd0;
        sum8  = r_prnd4 + (41'd1 << 26);
        k     = 9'd150 - {1'b0, ce};
        mag16 = 42'd0;
        w16   = 16'd0;
        kk    = 8'd119 - ce;
        mag32 = 33'd0;
        o_push_item = '0;
        case (r_fmt4)
            FMT_U8: begin
                o_push_item.word     = {24'd0, (|sum8[40:35]) ? 8'hFF : sum8[34:27]};
                o_push_item.last_idx = 2'd0;
            end
            FMT_S16: begin
                if (ce != 8'd0 && k <= 9'd40) begin
                    mag16 = ({1'b0, r_prnd4} + (42'd1 << (k - 9'd1))) >> k;
                end
                if (r_bits4[31]) begin
                    w16 = (mag16 > 42'd32768) ? 16'h8000 : (~mag16[15:0] + 16'd1);
                end else begin
                    w16 = (mag16 > 42'd32767) ? 16'h7FFF : mag16[15:0];
                end
                o_push_item.word     = {16'd0, w16};
                o_push_item.last_idx = 2'd1;
            end
            FMT_S32: begin
                if (ce >= 8'd119) begin
                    mag32 = {9'd0, m} << (ce - 8'd119);
                end else if (kk <= 8'd24) begin
                    mag32 = ({9'd0, m} + (33'd1 << (kk - 8'd1))) >> kk;
                end
                if (r_bits4[31]) begin
                    o_push_item.word = ~mag32[31:0] + 32'd1;
                end else begin
                    o_push_item.word = (mag32 >= 33'h0_8000_0000) ? 32'h7FFF_FFFF
                                                                 : mag32[31:0];
                end
                o_push_item.last_idx = 2'd3;
            end
            default: begin
                o_push_item.word     = r_bits4;
                o_push_item.last_idx = 2'd3;
            end
        endcase
    end

    assign o_push = r_v4 && !i_queue_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_bits1 <= n_bits1;
            r_fmt1  <= i_fmt;
            r_bits2 <= r_bits1;
            r_fmt2  <= r_fmt1;
            r_t2    <= n_t2;
            r_bits3 <= r_bits2;
            r_fmt3  <= r_fmt2;
            r_prod3 <= n_prod3[39:0];
            r_bits4 <= r_bits3;
            r_fmt4  <= r_fmt3;
            r_prnd4 <= rne24(r_prod3);
        end
    end

endmodule

### rtl/fpcm_queue.sv
// small queue between the conversion pipeline and the byte serializer
`include "float_to_pcm_sample_converter_top_macros.svh"
module fpcm_queue #(
    parameter int unsigned DEPTH = 4,
    parameter int unsigned WIDTH = 34
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    `FPCM_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, i_push, !o_full)
    `FPCM_ASSERT_IMP(a_no_underrun, i_clk, i_rst_n, i_pop, !o_empty)
    `FPCM_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

### rtl/fpcm_back.sv
// back end: sends each queued word as little-endian bytes
module fpcm_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fpcm_pkg::t_queue_item i_item,
    input  logic                  i_empty,
    output logic                  o_pop,
    output logic                  o_tvalid,
    input  logic                  i_tready,
    output logic [7:0]            o_tdata,
    output logic                  o_tlast
);
    import fpcm_pkg::*;

    logic        r_valid;
    logic [31:0] r_word;
    logic [1:0]  r_idx;
    logic [1:0]  r_last_idx;
    logic        is_last;
    logic        load;

    assign is_last = (r_idx == r_last_idx);
    // take a new word when idle or when the final byte's transaction completes
    assign load    = !r_valid || (i_tready && is_last);
    assign o_pop   = load && !i_empty;

    assign o_tvalid = r_valid;
    assign o_tdata  = r_word[{r_idx, 3'b000} +: 8];
    assign o_tlast  = is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (load) begin
            r_valid <= !i_empty;
            r_idx   <= 2'd0;
        end else if (i_tready) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_word     <= i_item.word;
            r_last_idx <= i_item.last_idx;
        end
    end

endmodule

### rtl/float_to_pcm_sample_converter_top.sv
// float32 sample to pcm byte stream converter, top level
// throughput: a sample can be accepted every cycle into the four-stage front pipeline
// while a full queue does not stall it; the byte serializer sets the sustained rate,
// sending 1, 2 or 4 bytes per sample for unsigned 8-bit, signed 16-bit and 32-bit
// or float output
// synchronous active-low reset empties pipeline and queue and sets the format to 16-bit
module float_to_pcm_sample_converter_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pcm_byte
    output logic        m_axis_tlast
);
    import fpcm_pkg::*;

    t_fmt        r_out_fmt;
    logic        push;
    t_queue_item push_item;
    t_queue_item head_item;
    logic        pop;
    logic        q_full;
    logic        q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_fmt <= FMT_S16;
        end else if (i_cfg_wr_en) begin
            r_out_fmt <= t_fmt'(i_cfg_wr_data);
        end
    end

    fpcm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fmt        (r_out_fmt),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .o_push       (push),
        .o_push_item  (push_item),
        .i_queue_full (q_full)
    );

    fpcm_queue #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ITEM_W)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_wr_data (push_item),
        .i_pop     (pop),
        .o_rd_data (head_item),
        .o_full    (q_full),
        .o_empty   (q_empty)
    );

    fpcm_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (head_item),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule
